/* design/mcwa_pkg.sv */
// Package for the multi-channel window average block.
// Holds field widths, command, channel and register codes and the queue item type.
// No dependencies; every other file of the block but mcwa_div imports it.
`default_nettype none

package mcwa_pkg;

  localparam int TIME_W     = 32;
  localparam int CMD_W      = 2;
  localparam int CH_W       = 3;
  localparam int GRP_W      = 2;
  localparam int NUM_CH     = 6;
  localparam int NUM_GRP    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int WL_CFG_W   = 9;
  localparam int FIFO_DEPTH = 2;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_RENDER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ASIM   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SIM    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_IO     = 2'd3;

  // Channels, in result order.
  localparam logic [CH_W-1:0] CH_ACTIVE_RENDER = 3'd0;
  localparam logic [CH_W-1:0] CH_RENDER        = 3'd1;
  localparam logic [CH_W-1:0] CH_ACTIVE_SIM    = 3'd2;
  localparam logic [CH_W-1:0] CH_SIM           = 3'd3;
  localparam logic [CH_W-1:0] CH_INPUT         = 3'd4;
  localparam logic [CH_W-1:0] CH_AUDIO         = 3'd5;

  // Groups that share a fill count and a write position.
  localparam logic [GRP_W-1:0] GRP_RENDER = 2'd0;
  localparam logic [GRP_W-1:0] GRP_ASIM   = 2'd1;
  localparam logic [GRP_W-1:0] GRP_SIM    = 2'd2;
  localparam logic [GRP_W-1:0] GRP_IO     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SIM  = 1'd1;

  // One classified request waiting for the back end.
  typedef struct packed {
    logic [GRP_W-1:0]  grp;
    logic [CH_W-1:0]   ch_a;
    logic [CH_W-1:0]   ch_b;
    logic              pair;
    logic              asim;
    logic              io;
    logic [TIME_W-1:0] first_time;
    logic [TIME_W-1:0] second_time;
  } item_t;

endpackage

`default_nettype wire

/* design/mcwa_if.sv */
// Valid/ready channel interfaces for the request and result sides.
// Depends on mcwa_pkg for the field widths.
`default_nettype none

interface mcwa_in_if import mcwa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [TIME_W-1:0]   first_time;
  logic [TIME_W-1:0]   second_time;

  modport source (output valid, command, first_time, second_time, input ready);
  modport sink   (input valid, command, first_time, second_time, output ready);
endinterface

interface mcwa_out_if import mcwa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   avg_active_render;
  logic [TIME_W-1:0]   avg_render;
  logic [TIME_W-1:0]   avg_active_sim;
  logic [TIME_W-1:0]   avg_sim;
  logic [TIME_W-1:0]   avg_sim_input;
  logic [TIME_W-1:0]   avg_sim_audio;
  logic [TIME_W-1:0]   expected_sim_report;

  modport source (output valid, avg_active_render, avg_render, avg_active_sim, avg_sim,
                  avg_sim_input, avg_sim_audio, expected_sim_report, input ready);
  modport sink   (input valid, avg_active_render, avg_render, avg_active_sim, avg_sim,
                  avg_sim_input, avg_sim_audio, expected_sim_report, output ready);
endinterface

`default_nettype wire

/* design/mcwa_front.sv */
// Front end: accepts requests and classifies each command into its channel group.
// Depends on mcwa_pkg and mcwa_in_if; feeds mcwa_fifo.
`default_nettype none

module mcwa_front import mcwa_pkg::*; (
  mcwa_in_if.sink     in_if,
  input  logic        q_full,
  output logic        push,
  output item_t       push_item
);

  assign in_if.ready = !q_full;
  assign push        = in_if.valid && !q_full;

  always_comb begin
    push_item             = '0;
    push_item.first_time  = in_if.first_time;
    push_item.second_time = in_if.second_time;
    unique case (in_if.command)
      CMD_RENDER: begin
        push_item.grp  = GRP_RENDER;
        push_item.ch_a = CH_RENDER;
        push_item.ch_b = CH_ACTIVE_RENDER;
        push_item.pair = 1'b1;
      end
      CMD_ASIM: begin
        push_item.grp  = GRP_ASIM;
        push_item.ch_a = CH_ACTIVE_SIM;
        push_item.ch_b = CH_ACTIVE_SIM;
        push_item.asim = 1'b1;
      end
      CMD_SIM: begin
        push_item.grp  = GRP_SIM;
        push_item.ch_a = CH_SIM;
        push_item.ch_b = CH_SIM;
      end
      CMD_IO: begin
        push_item.grp  = GRP_IO;
        push_item.ch_a = CH_INPUT;
        push_item.ch_b = CH_AUDIO;
        push_item.pair = 1'b1;
        push_item.io   = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/mcwa_fifo.sv */
// Short request queue between the front end and the back end.
// Depends on mcwa_pkg for item_t and FIFO_DEPTH.
`default_nettype none

module mcwa_fifo import mcwa_pkg::*; #(
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  item_t            push_item,
  output logic             full,
  input  logic             pop,
  output logic             pop_vld,
  output item_t            pop_item,
  output logic [CNT_W-1:0] cnt
);

  localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

  item_t            slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign pop_item = slot_r[rd_ptr_r];
  assign cnt      = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/mcwa_div.sv */
// One lane of the restoring divider: one quotient bit per step.
// Used six times by mcwa_back; no package dependency.
`default_nettype none

module mcwa_div #(
  parameter int SUM_W = 40,
  parameter int LEN_W = 9
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [SUM_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic [31:0]      quotient
);

  logic [LEN_W-1:0] rem_r;
  logic [SUM_W-1:0] quo_r;
  logic [LEN_W:0]   shifted;
  logic             fits;

  assign shifted  = {rem_r, quo_r[SUM_W-1]};
  assign fits     = (shifted >= {1'b0, divisor});
  assign quotient = quo_r[31:0];

  // The remainder stays below the divisor, so it always fits in LEN_W bits.
  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (step) begin
      rem_r <= fits ? LEN_W'(shifted - {1'b0, divisor}) : LEN_W'(shifted);
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

/* design/mcwa_back.sv */
// Back end: sample ring memory, running sums, group counters, dividers, result register.
// Depends on mcwa_pkg, mcwa_out_if and mcwa_div.
`default_nettype none

module mcwa_back import mcwa_pkg::*; #(
  parameter  int WINDOW_MAX = 256,
  localparam int LEN_W = $clog2(WINDOW_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_vld,
  input  item_t             q_item,
  output logic              q_pop,
  input  logic [LEN_W-1:0]  wl,
  input  logic              clr,
  input  logic [TIME_W-1:0] exp_sim,
  mcwa_out_if.source        out_if
);

  localparam int SUM_W  = TIME_W + $clog2(WINDOW_MAX);
  localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int ADDR_W = CH_W + PTR_W;
  localparam int CNT_W  = $clog2(SUM_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_UPB  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  item_t             ent_r;
  logic [TIME_W-1:0] val_a_r;
  logic              full_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [SUM_W-1:0]  sums_r  [NUM_CH];
  logic [LEN_W-1:0]  fill_r  [NUM_GRP];
  logic [PTR_W-1:0]  pos_r   [NUM_GRP];
  logic [TIME_W-1:0] newest_in_r;
  logic [TIME_W-1:0] newest_au_r;

  logic [TIME_W-1:0] ring_mem [0:(NUM_CH << PTR_W) - 1];
  logic [TIME_W-1:0] mem_rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [TIME_W-1:0] mem_wdata;

  logic              out_vld_r;
  logic [TIME_W-1:0] out_avg_r [NUM_CH];
  logic [TIME_W-1:0] out_exp_r;
  logic [TIME_W-1:0] quo [NUM_CH];

  logic [PTR_W-1:0]  pos;
  logic [LEN_W:0]    pos_inc;
  logic [TIME_W:0]   io_sum;
  logic [TIME_W-1:0] asim_val;
  logic [CH_W-1:0]   upd_ch;
  logic [TIME_W-1:0] upd_val;
  logic [SUM_W-1:0]  sum_new;
  logic              div_load;
  logic              div_step;
  logic              out_load;

  assign pos     = pos_r[ent_r.grp];
  assign pos_inc = {1'b0, LEN_W'(pos)} + 1'b1;

  // Active sim sample: first time less the newest input and audio, floored at zero.
  assign io_sum   = {1'b0, newest_in_r} + {1'b0, newest_au_r};
  assign asim_val = ({1'b0, ent_r.first_time} > io_sum) ?
                    (ent_r.first_time - io_sum[TIME_W-1:0]) : '0;

  assign upd_ch  = (state_r == S_RDB) ? ent_r.ch_a : ent_r.ch_b;
  assign upd_val = (state_r == S_RDB) ? val_a_r : ent_r.second_time;
  assign sum_new = sums_r[upd_ch] - (full_r ? SUM_W'(mem_rdata_r) : '0) + SUM_W'(upd_val);

  assign mem_raddr = (state_r == S_RDA) ? {ent_r.ch_a, pos} : {ent_r.ch_b, pos};
  assign mem_waddr = (state_r == S_RDB) ? {ent_r.ch_a, pos} : {ent_r.ch_b, pos};
  assign mem_wdata = upd_val;
  assign mem_we    = (state_r == S_RDB) || ((state_r == S_UPB) && ent_r.pair);

  assign q_pop    = (state_r == S_IDLE) && q_vld && !clr;
  assign div_load = (state_r == S_LOAD);
  assign div_step = (state_r == S_DIV) && (cnt_r != '0);
  assign out_load = (state_r == S_DIV) && (cnt_r == '0) && (!out_vld_r || out_if.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q_pop) state_nxt = S_RDA;
      S_RDA:   state_nxt = S_RDB;
      S_RDB:   state_nxt = S_UPB;
      S_UPB:   state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Ring memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= ring_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_item;
    end
    if (state_r == S_RDA) begin
      val_a_r <= ent_r.asim ? asim_val : ent_r.first_time;
      full_r  <= (fill_r[ent_r.grp] >= wl);
    end
    if (div_load) begin
      cnt_r <= CNT_W'(SUM_W);
    end else if (div_step) begin
      cnt_r <= cnt_r - 1'b1;
    end
    if (out_load) begin
      for (int k = 0; k < NUM_CH; k++) begin
        out_avg_r[k] <= quo[k];
      end
      out_exp_r <= exp_sim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_vld_r   <= 1'b0;
      newest_in_r <= '0;
      newest_au_r <= '0;
      for (int k = 0; k < NUM_CH; k++) begin
        sums_r[k] <= '0;
      end
      for (int g = 0; g < NUM_GRP; g++) begin
        fill_r[g] <= '0;
        pos_r[g]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
      if (clr) begin
        newest_in_r <= '0;
        newest_au_r <= '0;
        for (int k = 0; k < NUM_CH; k++) begin
          sums_r[k] <= '0;
        end
        for (int g = 0; g < NUM_GRP; g++) begin
          fill_r[g] <= '0;
          pos_r[g]  <= '0;
        end
      end else begin
        if (state_r == S_RDB) begin
          sums_r[upd_ch] <= sum_new;
        end
        if (state_r == S_UPB) begin
          if (ent_r.pair) begin
            sums_r[upd_ch] <= sum_new;
          end
          pos_r[ent_r.grp] <= (pos_inc >= {1'b0, wl}) ? '0 : PTR_W'(pos_inc);
          if (fill_r[ent_r.grp] < wl) begin
            fill_r[ent_r.grp] <= fill_r[ent_r.grp] + 1'b1;
          end
          if (ent_r.io) begin
            newest_in_r <= ent_r.first_time;
            newest_au_r <= ent_r.second_time;
          end
        end
      end
    end
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_div
    mcwa_div #(
      .SUM_W (SUM_W),
      .LEN_W (LEN_W)
    ) u_div (
      .clk      (clk),
      .load     (div_load),
      .step     (div_step),
      .dividend (sums_r[k]),
      .divisor  (wl),
      .quotient (quo[k])
    );
  end

  assign out_if.valid               = out_vld_r;
  assign out_if.avg_active_render   = out_avg_r[CH_ACTIVE_RENDER];
  assign out_if.avg_render          = out_avg_r[CH_RENDER];
  assign out_if.avg_active_sim      = out_avg_r[CH_ACTIVE_SIM];
  assign out_if.avg_sim             = out_avg_r[CH_SIM];
  assign out_if.avg_sim_input       = out_avg_r[CH_INPUT];
  assign out_if.avg_sim_audio       = out_avg_r[CH_AUDIO];
  assign out_if.expected_sim_report = out_exp_r;

endmodule

`default_nettype wire

/* design/multi_channel_window_average_top.sv */
// Top level of the multi-channel window average block: configuration registers,
// front end, request queue and back end. Depends on mcwa_pkg, mcwa_if and all submodules.
//
// Usage: each request on in_chan carries a command and one or two times in
// nanoseconds; it feeds the render pair, active sim, sim, or input/audio pair.
// Every request yields one result on out_chan with the six channel averages
// (running sum over the window divided by the window length) and the expected
// sim time. Configuration writes on cfg_we/cfg_index/cfg_data: index 0 sets the
// window length from the low nine bits of cfg_data (0 reads as 1, clamped to
// WINDOW_MAX) and clears all history; index 1 sets the expected sim time. Write
// them only while the block is idle. Flow: a request is popped from the queue, then
// two ring memory reads with their sum updates and the divider load follow, then one
// divider step per sum bit (the sum is 32 + log2(WINDOW_MAX) bits wide) in six
// parallel lanes, and last the load of the result register. The back end takes one
// request at a time: it pops the next one only after the last result is loaded; the
// two-entry queue lets the sender run ahead by two requests.
// A stalled receiver holds the result register; the back end then waits with
// its next result and the queue fills before in_chan.ready drops.
// Reset (synchronous, rst_n low) sets the window length to 256 (or to WINDOW_MAX if
// smaller), clears sums, counters and newest input/audio; no clearing pass is needed.
`default_nettype none

module multi_channel_window_average_top import mcwa_pkg::*; #(
  parameter int WINDOW_MAX = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mcwa_in_if.sink               in_chan,
  mcwa_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int QCNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int WL_RST = (WINDOW_MAX < 256) ? WINDOW_MAX : 256;

  logic [LEN_W-1:0]    wl_r;
  logic [TIME_W-1:0]   exp_sim_r;
  logic [WL_CFG_W-1:0] wl_raw;
  logic                clr;
  logic                push;
  item_t               push_item;
  logic                q_full;
  logic                q_pop;
  logic                q_vld;
  item_t               q_item;
  logic [QCNT_W-1:0]   q_cnt;

  assign wl_raw = cfg_data[WL_CFG_W-1:0];
  assign clr    = cfg_we && (cfg_index == REG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r      <= LEN_W'(WL_RST);
      exp_sim_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: begin
          if (wl_raw == '0) begin
            wl_r <= LEN_W'(1);
          end else if (32'(wl_raw) > 32'(WINDOW_MAX)) begin
            wl_r <= LEN_W'(WINDOW_MAX);
          end else begin
            wl_r <= LEN_W'(wl_raw);
          end
        end
        REG_EXPECTED_SIM: exp_sim_r <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  mcwa_front u_front (
    .in_if     (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  mcwa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_vld   (q_vld),
    .pop_item  (q_item),
    .cnt       (q_cnt)
  );

  mcwa_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_vld   (q_vld),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .wl      (wl_r),
    .clr     (clr),
    .exp_sim (exp_sim_r),
    .out_if  (out_chan)
  );

  // The window length register never leaves its legal range.
  a_wl_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wl_r != '0) && (32'(wl_r) <= 32'(WINDOW_MAX)))
    else $error("window length register out of range");

  // An accepted request is in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (q_cnt != '0))
    else $error("accepted request missing from queue");

  // The back end only takes a request that the queue holds.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_cnt != '0))
    else $error("queue popped while empty");

  // Queue occupancy stays within its depth.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_cnt) <= 32'(FIFO_DEPTH))
    else $error("queue count exceeds depth");

endmodule

`default_nettype wire
